FILE: hw/rtl/packet_forward_ttl_stats_top_macros.svh
// Assertion macros shared by the packet forwarding RTL
`ifndef PACKET_FORWARD_TTL_STATS_TOP_MACROS_SVH
`define PACKET_FORWARD_TTL_STATS_TOP_MACROS_SVH

// implication checked every clock outside reset
`define PFTS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked on the following clock
`define PFTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/pfts_pkg.sv
// Shared types and constants for the packet forwarding block
package pfts_pkg;

	localparam logic [1:0] MODE_PKT   = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	localparam logic [2:0] ST_FWD      = 3'd0;
	localparam logic [2:0] ST_BADPORT  = 3'd1;
	localparam logic [2:0] ST_INDIS    = 3'd2;
	localparam logic [2:0] ST_OVERMTU  = 3'd3;
	localparam logic [2:0] ST_TTLEXP   = 3'd4;
	localparam logic [2:0] ST_OUTDIS   = 3'd5;
	localparam logic [2:0] ST_READDONE = 3'd6;
	localparam logic [2:0] ST_CLEARED  = 3'd7;

	localparam logic [2:0] SEL_RXPKT  = 3'd0;
	localparam logic [2:0] SEL_TXPKT  = 3'd1;
	localparam logic [2:0] SEL_RXBYTE = 3'd2;
	localparam logic [2:0] SEL_TXBYTE = 3'd3;
	localparam logic [2:0] SEL_RXERR  = 3'd4;
	localparam logic [2:0] SEL_TXERR  = 3'd5;
	localparam logic [2:0] SEL_TTLEXP = 3'd6;

	localparam logic [1:0] REG_PORT_EN = 2'd0;
	localparam logic [1:0] REG_MTU0    = 2'd1;
	localparam logic [1:0] REG_MTU1    = 2'd2;
	localparam logic [1:0] REG_MTU2    = 2'd3;

	localparam int        CFG_PORTS = 3;
	localparam logic [15:0] MTU_RESET = 16'd1500;
	localparam int        CFG_IDX_W = 2;

	// classified request handed from front to back
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  in_port;
		logic [7:0]  dst;
		logic [15:0] pkt_size;
		logic [7:0]  out_ttl;
		logic [1:0]  counter_port;
		logic [2:0]  counter_select;
		logic        do_clear;
		logic        do_read;
	} cmd_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;

endpackage

FILE: hw/rtl/pfts_front.sv
// Front end: request intake, classification and command queue
module pfts_front #(
	parameter int NUM_PORTS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid,
	output logic                ready,
	input  logic [1:0]          mode,
	input  logic [7:0]          in_port,
	input  logic [15:0]         pkt_size,
	input  logic [7:0]          ttl,
	input  logic                is_ipv4,
	input  logic [1:0]          counter_port,
	input  logic [2:0]          counter_select,
	input  logic [2:0]          port_enable,
	input  logic [15:0]         mtu_port0,
	input  logic [15:0]         mtu_port1,
	input  logic [15:0]         mtu_port2,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output pfts_pkg::cmd_t      cmd
);

	pfts_pkg::cmd_t c;
	pfts_pkg::cmd_t q_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       push, pop, en_in, en_dst;
	logic [15:0] mtu;
	logic [7:0]  dst;

	always_comb begin
		en_in = 1'b1;
		mtu = pfts_pkg::MTU_RESET;
		if (in_port < 8'(pfts_pkg::CFG_PORTS)) begin
			en_in = port_enable[in_port[1:0]];
			unique case (in_port[1:0])
				2'd0: mtu = mtu_port0;
				2'd1: mtu = mtu_port1;
				default: mtu = mtu_port2;
			endcase
		end
		dst = (in_port == 8'(NUM_PORTS - 1)) ? 8'd0 : in_port + 8'd1;
		en_dst = (dst < 8'(pfts_pkg::CFG_PORTS)) ? port_enable[dst[1:0]] : 1'b1;
		c = '0;
		c.in_port = in_port;
		c.dst = dst;
		c.pkt_size = pkt_size;
		c.out_ttl = ttl;
		c.counter_port = counter_port;
		c.counter_select = counter_select;
		priority if (mode == pfts_pkg::MODE_READ || mode == pfts_pkg::MODE_NOP) begin
			c.status = pfts_pkg::ST_READDONE;
			c.do_read = (mode == pfts_pkg::MODE_READ);
		end else if (mode == pfts_pkg::MODE_CLEAR) begin
			c.status = pfts_pkg::ST_CLEARED;
			c.do_clear = 1'b1;
		end else if (in_port >= 8'(NUM_PORTS)) begin
			c.status = pfts_pkg::ST_BADPORT;
			c.in_port = 8'd0;
		end else if (!en_in) begin
			c.status = pfts_pkg::ST_INDIS;
		end else if (pkt_size > mtu) begin
			c.status = pfts_pkg::ST_OVERMTU;
		end else if ((is_ipv4 || ttl != 8'd0) && ttl <= 8'd1) begin
			c.status = pfts_pkg::ST_TTLEXP;
		end else begin
			if (is_ipv4 || ttl != 8'd0) c.out_ttl = ttl - 8'd1;
			c.status = en_dst ? pfts_pkg::ST_FWD : pfts_pkg::ST_OUTDIS;
		end
	end

	assign ready = (cnt_q != 2'd2);
	assign push = valid && ready;
	assign pop = cmd_valid && cmd_ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= c;
	end

endmodule

FILE: hw/rtl/pfts_back.sv
// Back end: counter update, counter read and result register
`include "packet_forward_ttl_stats_top_macros.svh"
module pfts_back #(
	parameter int NUM_PORTS     = 3,
	parameter int COUNTER_WIDTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  pfts_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     status,
	output logic [1:0]     fwd_port,
	output logic [7:0]     out_ttl,
	output logic [63:0]    counter_value
);

	localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	typedef logic [COUNTER_WIDTH-1:0] cnt_t;

	cnt_t rxp_q [NUM_PORTS];
	cnt_t txp_q [NUM_PORTS];
	cnt_t rxb_q [NUM_PORTS];
	cnt_t txb_q [NUM_PORTS];
	cnt_t rxe_q [NUM_PORTS];
	cnt_t txe_q [NUM_PORTS];
	cnt_t ttl_q [NUM_PORTS];

	logic        ov_q;
	logic [2:0]  st_q;
	logic [1:0]  op_q;
	logic [7:0]  ot_q;
	logic [63:0] cv_q;
	logic        go;
	logic [PW-1:0] ip, dp, cp;
	cnt_t        rd;
	cnt_t        sz;

	assign cmd_ready = !ov_q || out_ready;
	assign go = cmd_valid && cmd_ready;
	assign ip = cmd.in_port[PW-1:0];
	assign dp = cmd.dst[PW-1:0];
	assign cp = PW'(cmd.counter_port);
	assign sz = COUNTER_WIDTH'(cmd.pkt_size);

	always_comb begin
		rd = '0;
		if (32'(cmd.counter_port) < NUM_PORTS) begin
			unique case (cmd.counter_select)
				pfts_pkg::SEL_RXPKT:  rd = rxp_q[cp];
				pfts_pkg::SEL_TXPKT:  rd = txp_q[cp];
				pfts_pkg::SEL_RXBYTE: rd = rxb_q[cp];
				pfts_pkg::SEL_TXBYTE: rd = txb_q[cp];
				pfts_pkg::SEL_RXERR:  rd = rxe_q[cp];
				pfts_pkg::SEL_TXERR:  rd = txe_q[cp];
				pfts_pkg::SEL_TTLEXP: rd = ttl_q[cp];
				default:              rd = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				rxp_q[i] <= '0; txp_q[i] <= '0; rxb_q[i] <= '0; txb_q[i] <= '0;
				rxe_q[i] <= '0; txe_q[i] <= '0; ttl_q[i] <= '0;
			end
		end else begin
			if (go) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			if (go) begin
				if (cmd.do_clear) begin
					for (int i = 0; i < NUM_PORTS; i++) begin
						rxp_q[i] <= '0; txp_q[i] <= '0; rxb_q[i] <= '0; txb_q[i] <= '0;
						rxe_q[i] <= '0; txe_q[i] <= '0; ttl_q[i] <= '0;
					end
				end else begin
					unique case (cmd.status)
						pfts_pkg::ST_BADPORT, pfts_pkg::ST_INDIS, pfts_pkg::ST_OVERMTU:
							rxe_q[ip] <= rxe_q[ip] + 1'b1;
						pfts_pkg::ST_TTLEXP: begin
							rxp_q[ip] <= rxp_q[ip] + 1'b1;
							rxb_q[ip] <= rxb_q[ip] + sz;
							ttl_q[ip] <= ttl_q[ip] + 1'b1;
						end
						pfts_pkg::ST_OUTDIS: begin
							rxp_q[ip] <= rxp_q[ip] + 1'b1;
							rxb_q[ip] <= rxb_q[ip] + sz;
							txe_q[dp] <= txe_q[dp] + 1'b1;
						end
						pfts_pkg::ST_FWD: begin
							rxp_q[ip] <= rxp_q[ip] + 1'b1;
							rxb_q[ip] <= rxb_q[ip] + sz;
							txp_q[dp] <= txp_q[dp] + 1'b1;
							txb_q[dp] <= txb_q[dp] + sz;
						end
						default: ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			st_q <= cmd.status;
			op_q <= (cmd.status == pfts_pkg::ST_FWD || cmd.status == pfts_pkg::ST_OUTDIS)
				? cmd.dst[1:0] : 2'd0;
			ot_q <= cmd.out_ttl;
			cv_q <= cmd.do_read ? 64'(rd) : 64'd0;
		end
	end

	assign out_valid = ov_q;
	assign status = st_q;
	assign fwd_port = op_q;
	assign out_ttl = ot_q;
	assign counter_value = cv_q;

	`PFTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(st_q),
		"result lost while stalled")
	`PFTS_ASSERT_IMP(a_take_when_free, !out_valid && cmd_valid, cmd_ready,
		"back end stalled with empty output")
	`PFTS_ASSERT_NEXT(a_load, go, out_valid, "accepted request produced no result")

endmodule

FILE: hw/rtl/packet_forward_ttl_stats_top.sv
// Top level of the packet forwarding and statistics block
//  channel | signals                                     | dir
//  in      | valid ready mode in_port pkt_size ttl ...   | request in
//  out     | out_valid out_ready status fwd_port ...     | result out
//  cfg     | cfg_we cfg_index cfg_data                   | register write
// One request per cycle if out_ready is high; results are queued then registered.
// A two-entry queue parts classification from counter update; the output register
// holds a stalled result while the queue takes up to two more requests.
// Reset clears counters, restores enables and MTUs; no clearing pass.
module packet_forward_ttl_stats_top #(
	parameter int NUM_PORTS     = 3,
	parameter int COUNTER_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  in_port,
	input  logic [15:0] pkt_size,
	input  logic [7:0]  ttl,
	input  logic        is_ipv4,
	input  logic [1:0]  counter_port,
	input  logic [2:0]  counter_select,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [1:0]  fwd_port,
	output logic [7:0]  out_ttl,
	output logic [63:0] counter_value,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [2:0]  en_q;
	logic [15:0] mtu0_q, mtu1_q, mtu2_q;
	logic        cmd_valid, cmd_ready;
	pfts_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 3'd7;
			mtu0_q <= pfts_pkg::MTU_RESET;
			mtu1_q <= pfts_pkg::MTU_RESET;
			mtu2_q <= pfts_pkg::MTU_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfts_pkg::REG_PORT_EN: en_q <= cfg_data[2:0];
				pfts_pkg::REG_MTU0:    mtu0_q <= cfg_data;
				pfts_pkg::REG_MTU1:    mtu1_q <= cfg_data;
				pfts_pkg::REG_MTU2:    mtu2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pfts_front #(.NUM_PORTS(NUM_PORTS)) u_front (
		.clk, .arst_n, .valid, .ready, .mode, .in_port, .pkt_size, .ttl, .is_ipv4,
		.counter_port, .counter_select, .port_enable(en_q), .mtu_port0(mtu0_q),
		.mtu_port1(mtu1_q), .mtu_port2(mtu2_q), .cmd_valid, .cmd_ready, .cmd
	);

	pfts_back #(.NUM_PORTS(NUM_PORTS), .COUNTER_WIDTH(COUNTER_WIDTH)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
		.status, .fwd_port, .out_ttl, .counter_value
	);

endmodule
